@@ hdl/sfmb_pkg.sv @@
// Shared widths, stage numbering, codes and item types of the snow and firn mass balance pipeline.
package sfmb_pkg;

    localparam int TEMP_W  = 17;
    localparam int DEPTH_W = 29;
    localparam int MELT_W  = 30;
    localparam int CHG_W   = 31;
    localparam int SNOW_W  = DEPTH_W + 1;
    localparam int FS_W    = DEPTH_W + 2;
    localparam int SUM_W   = 32;

    localparam int FRAC_BITS = 16;
    localparam int FRAC_W    = FRAC_BITS + 1;
    localparam int PROD_W    = FRAC_W + MELT_W;

    localparam int DIV_BITS_PER_STAGE = 2;
    localparam int DIV_STAGES         = FRAC_BITS / DIV_BITS_PER_STAGE;

    localparam int ST_IN        = 0;
    localparam int ST_DIV_FIRST = 1;
    localparam int ST_DIV_LAST  = ST_DIV_FIRST + DIV_STAGES;
    localparam int ST_MELT_DONE = 6;
    localparam int ST_MUL       = ST_DIV_LAST + 1;
    localparam int ST_RFZ       = ST_MUL + 1;
    localparam int ST_OUT       = ST_RFZ + 1;
    localparam int STAGES       = ST_OUT + 1;

    localparam int S_TDATA_W = 168;
    localparam int M_TDATA_W = 160;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = TEMP_W;

    localparam logic [CFG_IDX_W-1:0] CFG_ALL_MELT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_T_FULL   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_T_NONE   = 2'd2;

    localparam logic              RST_ALL_MELT = 1'b1;
    localparam logic [TEMP_W-1:0] RST_T_FULL   = 17'd68608;
    localparam logic [TEMP_W-1:0] RST_T_NONE   = 17'd69888;

    localparam logic [FRAC_W-1:0] FRAC_ONE  = 17'h10000;
    localparam logic [FRAC_W-1:0] FRAC_ZERO = 17'h00000;

    typedef enum logic [1:0] {
        CLS_FULL,
        CLS_DIV,
        CLS_ZERO
    } frac_cls_t;

    typedef struct packed {
        logic [STAGES-1:0] load;
    } pipe_ctrl_t;

    typedef struct packed {
        logic [TEMP_W-1:0]        air_temp;
        logic [DEPTH_W-1:0]       thickness;
        logic signed [MELT_W-1:0] melt_amount;
        logic [DEPTH_W-1:0]       old_firn;
        logic [DEPTH_W-1:0]       old_snow;
        logic [DEPTH_W-1:0]       accumulation;
    } in_item_t;

    typedef struct packed {
        logic [DEPTH_W-1:0]       thick;
        logic [DEPTH_W-1:0]       old_firn;
        logic [DEPTH_W-1:0]       old_snow;
        logic [DEPTH_W-1:0]       acc;
        logic signed [MELT_W-1:0] melt;
        logic [SNOW_W-1:0]        snow;
        logic [DEPTH_W-1:0]       firn;
        logic [SNOW_W-1:0]        snow_m;
        logic [DEPTH_W-1:0]       firn_m;
        logic [DEPTH_W-1:0]       mm;
        logic                     pos;
        logic                     le_s;
        logic                     le_fs;
        logic signed [SUM_W-1:0]  am;
        logic signed [SUM_W-1:0]  tam;
    } melt_wk_t;

    typedef struct packed {
        logic [CHG_W-1:0]         firn_chg;
        logic [CHG_W-1:0]         snow_chg;
        logic signed [MELT_W-1:0] melt;
        logic [MELT_W-1:0]        vmag;
        logic                     vneg;
        logic signed [SUM_W-1:0]  am;
        logic signed [SUM_W-1:0]  tam;
        logic [DEPTH_W-1:0]       thick;
    } melt_res_t;

endpackage

@@ hdl/sfmb_frac_div.sv @@
// Refreeze fraction: temperature classing and a pipelined restoring divider.
module sfmb_frac_div (
    input  logic                             aclk,
    input  sfmb_pkg::pipe_ctrl_t             ctrl,
    input  logic [sfmb_pkg::TEMP_W-1:0]      air_temp,
    input  logic [sfmb_pkg::TEMP_W-1:0]      t_full,
    input  logic [sfmb_pkg::TEMP_W-1:0]      t_none,
    output logic [sfmb_pkg::FRAC_W-1:0]      frac
);

    localparam int TW = sfmb_pkg::TEMP_W;
    localparam int FB = sfmb_pkg::FRAC_BITS;
    localparam int NS = sfmb_pkg::DIV_STAGES;

    logic [TW-1:0]         div_reg;
    logic [TW-1:0]         rem_reg [0:NS];
    logic [FB-1:0]         quo_reg [0:NS];
    sfmb_pkg::frac_cls_t   cls_reg [0:NS];
    sfmb_pkg::frac_cls_t   cls_next;
    logic [TW-1:0]         rem_next;

    always_comb begin
        if (air_temp <= t_full) begin
            cls_next = sfmb_pkg::CLS_FULL;
        end else if (air_temp <= t_none) begin
            cls_next = sfmb_pkg::CLS_DIV;
        end else begin
            cls_next = sfmb_pkg::CLS_ZERO;
        end
        rem_next = TW'(t_none - air_temp);
    end

    always_ff @(posedge aclk) begin
        div_reg <= TW'(t_none - t_full);
        if (ctrl.load[sfmb_pkg::ST_DIV_FIRST]) begin
            cls_reg[0] <= cls_next;
            rem_reg[0] <= rem_next;
            quo_reg[0] <= '0;
        end
    end

    for (genvar j = 1; j <= NS; j++) begin : g_div
        logic [TW-1:0] r_next;
        logic [FB-1:0] q_next;

        always_comb begin
            logic [TW-1:0] r;
            logic [TW:0]   r2;
            logic [FB-1:0] q;
            r = rem_reg[j-1];
            q = quo_reg[j-1];
            for (int b = 0; b < sfmb_pkg::DIV_BITS_PER_STAGE; b++) begin
                r2 = {r, 1'b0};
                if (r2 >= {1'b0, div_reg}) begin
                    r = TW'(r2 - {1'b0, div_reg});
                    q = {q[FB-2:0], 1'b1};
                end else begin
                    r = r2[TW-1:0];
                    q = {q[FB-2:0], 1'b0};
                end
            end
            r_next = r;
            q_next = q;
        end

        always_ff @(posedge aclk) begin
            if (ctrl.load[sfmb_pkg::ST_DIV_FIRST + j]) begin
                rem_reg[j] <= r_next;
                quo_reg[j] <= q_next;
                cls_reg[j] <= cls_reg[j-1];
            end
        end
    end

    always_comb begin
        unique case (cls_reg[NS])
            sfmb_pkg::CLS_FULL: frac = sfmb_pkg::FRAC_ONE;
            sfmb_pkg::CLS_DIV:  frac = {1'b0, quo_reg[NS]};
            sfmb_pkg::CLS_ZERO: frac = sfmb_pkg::FRAC_ZERO;
            default:            frac = sfmb_pkg::FRAC_ZERO;
        endcase
    end

endmodule

@@ hdl/sfmb_melt.sv @@
// Snow and firn clamping, accumulation, melt partition and depth changes.
module sfmb_melt (
    input  logic                  aclk,
    input  sfmb_pkg::pipe_ctrl_t  ctrl,
    input  sfmb_pkg::in_item_t    item,
    input  logic                  all_melt,
    output sfmb_pkg::melt_res_t   res
);

    localparam int DW = sfmb_pkg::DEPTH_W;
    localparam int SW = sfmb_pkg::SNOW_W;
    localparam int FW = sfmb_pkg::FS_W;
    localparam int MW = sfmb_pkg::MELT_W;
    localparam int CW = sfmb_pkg::CHG_W;
    localparam int UW = sfmb_pkg::SUM_W;
    localparam int FIRST = sfmb_pkg::ST_MELT_DONE;
    localparam int LAST  = sfmb_pkg::ST_DIV_LAST;

    sfmb_pkg::melt_wk_t  w1_reg, w2_reg, w3_reg, w4_reg, w5_reg;
    sfmb_pkg::melt_wk_t  w1_next, w2_next, w3_next, w4_next, w5_next;
    sfmb_pkg::melt_res_t res_next;
    sfmb_pkg::melt_res_t res_reg [FIRST:LAST];

    always_comb begin
        w1_next          = '0;
        w1_next.thick    = item.thickness;
        w1_next.old_firn = item.old_firn;
        w1_next.old_snow = item.old_snow;
        w1_next.acc      = item.accumulation;
        w1_next.melt     = item.melt_amount;
        w1_next.snow     = SW'((item.old_snow < item.thickness) ? item.old_snow
                                                               : item.thickness);
        w1_next.am       = $signed(UW'(item.accumulation)) - UW'($signed(item.melt_amount));
    end

    always_comb begin
        logic [DW-1:0] room;
        room         = w1_reg.thick - w1_reg.snow[DW-1:0];
        w2_next      = w1_reg;
        w2_next.firn = (w1_reg.old_firn < room) ? w1_reg.old_firn : room;
        w2_next.snow = SW'(w1_reg.snow) + SW'(w1_reg.acc);
        w2_next.tam  = w1_reg.am + $signed(UW'(w1_reg.thick));
    end

    always_comb begin
        logic [FW-1:0] fs;
        logic [FW-1:0] mpos;
        fs            = FW'(w2_reg.firn) + FW'(w2_reg.snow);
        mpos          = FW'(w2_reg.melt[DW-1:0]);
        w3_next       = w2_reg;
        w3_next.pos   = !w2_reg.melt[MW-1] && (w2_reg.melt != '0);
        w3_next.le_s  = mpos <= FW'(w2_reg.snow);
        w3_next.le_fs = mpos <= fs;
    end

    always_comb begin
        w4_next = w3_reg;
        if (!w3_reg.pos) begin
            w4_next.snow_m = '0;
            w4_next.firn_m = '0;
        end else if (w3_reg.le_s) begin
            w4_next.snow_m = SW'(w3_reg.melt[DW-1:0]);
            w4_next.firn_m = '0;
        end else if (w3_reg.le_fs) begin
            w4_next.snow_m = w3_reg.snow;
            w4_next.firn_m = DW'(w3_reg.melt[DW-1:0] - w3_reg.snow[DW-1:0]);
        end else begin
            w4_next.snow_m = w3_reg.snow;
            w4_next.firn_m = w3_reg.firn;
        end
    end

    always_comb begin
        w5_next      = w4_reg;
        w5_next.snow = w4_reg.snow - w4_reg.snow_m;
        w5_next.firn = w4_reg.firn - w4_reg.firn_m;
        w5_next.mm   = DW'(w4_reg.snow_m[DW-1:0] + w4_reg.firn_m);
    end

    always_comb begin
        logic signed [MW-1:0] v;
        v                 = all_melt ? w5_reg.melt : $signed(MW'(w5_reg.mm));
        res_next.firn_chg = CW'(w5_reg.firn) - CW'(w5_reg.old_firn);
        res_next.snow_chg = CW'(w5_reg.snow) - CW'(w5_reg.old_snow);
        res_next.melt     = w5_reg.melt;
        res_next.vneg     = v[MW-1];
        res_next.vmag     = v[MW-1] ? MW'(-v) : MW'(v);
        res_next.am       = w5_reg.am;
        res_next.tam      = w5_reg.tam;
        res_next.thick    = w5_reg.thick;
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load[1]) begin
            w1_reg <= w1_next;
        end
        if (ctrl.load[2]) begin
            w2_reg <= w2_next;
        end
        if (ctrl.load[3]) begin
            w3_reg <= w3_next;
        end
        if (ctrl.load[4]) begin
            w4_reg <= w4_next;
        end
        if (ctrl.load[5]) begin
            w5_reg <= w5_next;
        end
        if (ctrl.load[FIRST]) begin
            res_reg[FIRST] <= res_next;
        end
    end

    for (genvar k = FIRST + 1; k <= LAST; k++) begin : g_hold
        always_ff @(posedge aclk) begin
            if (ctrl.load[k]) begin
                res_reg[k] <= res_reg[k-1];
            end
        end
    end

    assign res = res_reg[LAST];

endmodule

@@ hdl/sfmb_balance.sv @@
// Refrozen ice multiply, runoff and clamped mass balance with the result register.
module sfmb_balance (
    input  logic                               aclk,
    input  sfmb_pkg::pipe_ctrl_t               ctrl,
    input  logic [sfmb_pkg::FRAC_W-1:0]        frac,
    input  sfmb_pkg::melt_res_t                res,
    output logic [sfmb_pkg::CHG_W-1:0]         firn_change,
    output logic [sfmb_pkg::CHG_W-1:0]         snow_change,
    output logic [sfmb_pkg::MELT_W-1:0]        melt_out,
    output logic [sfmb_pkg::CHG_W-1:0]         runoff,
    output logic [sfmb_pkg::CHG_W-1:0]         mass_balance
);

    localparam int PW = sfmb_pkg::PROD_W;
    localparam int CW = sfmb_pkg::CHG_W;
    localparam int UW = sfmb_pkg::SUM_W;
    localparam int FB = sfmb_pkg::FRAC_BITS;

    logic [PW-1:0]           prod_reg, prod_next;
    sfmb_pkg::melt_res_t     r10_reg, r11_reg;
    logic signed [CW-1:0]    rfz_reg, rfz_next;
    logic signed [UW-1:0]    runoff_next, smb_next, smb_raw, tam_rfz;
    logic [CW-1:0]           firn_change_reg, snow_change_reg, runoff_reg, smb_reg;
    logic [sfmb_pkg::MELT_W-1:0] melt_reg;

    assign prod_next = PW'(frac) * PW'(res.vmag);

    always_comb begin
        logic signed [CW-1:0] mag;
        mag      = $signed(prod_reg[PW-1:FB]);
        rfz_next = r10_reg.vneg ? -mag : mag;
    end

    always_comb begin
        runoff_next = UW'(r11_reg.melt) - UW'(rfz_reg);
        smb_raw     = r11_reg.am + UW'(rfz_reg);
        tam_rfz     = r11_reg.tam + UW'(rfz_reg);
        smb_next    = tam_rfz[UW-1] ? -$signed(UW'(r11_reg.thick)) : smb_raw;
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load[sfmb_pkg::ST_MUL]) begin
            prod_reg <= prod_next;
            r10_reg  <= res;
        end
        if (ctrl.load[sfmb_pkg::ST_RFZ]) begin
            rfz_reg <= rfz_next;
            r11_reg <= r10_reg;
        end
        if (ctrl.load[sfmb_pkg::ST_OUT]) begin
            firn_change_reg <= r11_reg.firn_chg;
            snow_change_reg <= r11_reg.snow_chg;
            melt_reg        <= r11_reg.melt;
            runoff_reg      <= runoff_next[CW-1:0];
            smb_reg         <= smb_next[CW-1:0];
        end
    end

    assign firn_change  = firn_change_reg;
    assign snow_change  = snow_change_reg;
    assign melt_out     = melt_reg;
    assign runoff       = runoff_reg;
    assign mass_balance = smb_reg;

endmodule

@@ hdl/snow_firn_mass_balance_step.sv @@
// Top level of the snow and firn mass balance pipeline for one grid cell per request.
// The block takes one grid cell request per clock unless every stage is full and the
// output is stalled. Its result passes through every stage in order and is presented on
// the output from the result register. The thirteen register stages are the input
// register, the temperature classing stage, eight refreeze fraction divider stages that
// each produce two quotient bits, one stage for the fraction multiply, one for the signed
// refrozen ice, and the result register. Every stage has its own valid bit and
// moves forward whenever the stage after it is empty or moving, so gaps in the
// pipeline close up while the output is stalled. Configuration registers may be
// written only while no request is in flight; the write port is always ready.
module snow_firn_mass_balance_step (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // air_temp, thickness, melt_amount, old_firn, old_snow, accumulation, zero pad
    input  logic [sfmb_pkg::S_TDATA_W-1:0]       s_tdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // firn_change, snow_change, melt_out, runoff, mass_balance, zero pad
    output logic [sfmb_pkg::M_TDATA_W-1:0]       m_tdata,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [sfmb_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [sfmb_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int NST = sfmb_pkg::STAGES;
    localparam int TW  = sfmb_pkg::TEMP_W;
    localparam int PAD = sfmb_pkg::M_TDATA_W - 3 * sfmb_pkg::CHG_W - sfmb_pkg::CHG_W
                         - sfmb_pkg::MELT_W;

    logic [NST-1:0]        valid_reg;
    sfmb_pkg::pipe_ctrl_t  ctrl;
    sfmb_pkg::in_item_t    in_reg, in_next;
    logic                  all_melt_reg;
    logic [TW-1:0]         t_full_reg, t_none_reg;
    logic [sfmb_pkg::FRAC_W-1:0] frac;
    sfmb_pkg::melt_res_t   mres;
    logic [sfmb_pkg::CHG_W-1:0]  firn_change, snow_change, runoff, mass_balance;
    logic [sfmb_pkg::MELT_W-1:0] melt_out;

    for (genvar k = 0; k < NST; k++) begin : g_load
        assign ctrl.load[k] = m_tready | ~(&valid_reg[NST-1:k]);
    end

    assign s_tready  = ctrl.load[sfmb_pkg::ST_IN];
    assign m_tvalid  = valid_reg[sfmb_pkg::ST_OUT];
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (ctrl.load[0]) begin
                valid_reg[0] <= s_tvalid;
            end
            for (int k = 1; k < NST; k++) begin
                if (ctrl.load[k]) begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            all_melt_reg <= sfmb_pkg::RST_ALL_MELT;
            t_full_reg   <= sfmb_pkg::RST_T_FULL;
            t_none_reg   <= sfmb_pkg::RST_T_NONE;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                sfmb_pkg::CFG_ALL_MELT: all_melt_reg <= cfg_data[0];
                sfmb_pkg::CFG_T_FULL:   t_full_reg   <= cfg_data;
                sfmb_pkg::CFG_T_NONE:   t_none_reg   <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        in_next.air_temp     = s_tdata[16:0];
        in_next.thickness    = s_tdata[45:17];
        in_next.melt_amount  = $signed(s_tdata[75:46]);
        in_next.old_firn     = s_tdata[104:76];
        in_next.old_snow     = s_tdata[133:105];
        in_next.accumulation = s_tdata[162:134];
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load[sfmb_pkg::ST_IN]) begin
            in_reg <= in_next;
        end
    end

    sfmb_frac_div u_frac (
        .aclk     (aclk),
        .ctrl     (ctrl),
        .air_temp (in_reg.air_temp),
        .t_full   (t_full_reg),
        .t_none   (t_none_reg),
        .frac     (frac)
    );

    sfmb_melt u_melt (
        .aclk     (aclk),
        .ctrl     (ctrl),
        .item     (in_reg),
        .all_melt (all_melt_reg),
        .res      (mres)
    );

    sfmb_balance u_bal (
        .aclk         (aclk),
        .ctrl         (ctrl),
        .frac         (frac),
        .res          (mres),
        .firn_change  (firn_change),
        .snow_change  (snow_change),
        .melt_out     (melt_out),
        .runoff       (runoff),
        .mass_balance (mass_balance)
    );

    assign m_tdata = {{PAD{1'b0}}, mass_balance, runoff, melt_out, snow_change, firn_change};

    a_empty_out_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input not ready while the result register is empty");

    a_full_stall_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        ((&valid_reg) && !m_tready) |-> !s_tready)
        else $error("request taken while every stage is full and output is stalled");

    a_accept_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> valid_reg[sfmb_pkg::ST_IN])
        else $error("accepted request missing from the input stage");

endmodule

@@ tb/snow_firn_mass_balance_step_test.sv @@
// Self-checking testbench for the snow and firn mass balance step, with its own predictor.
module snow_firn_mass_balance_step_test;

    localparam int MT = 65536;
    localparam int DIR_ROWS = 20;
    localparam logic [sfmb_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam logic [sfmb_pkg::DEPTH_W-1:0] DEPTH_MAX = '1;
    localparam logic [sfmb_pkg::TEMP_W-1:0] TEMP_MAX = '1;

    typedef struct packed {
        logic [sfmb_pkg::TEMP_W-1:0]        air_temp;
        logic [sfmb_pkg::DEPTH_W-1:0]       thickness;
        logic signed [sfmb_pkg::MELT_W-1:0] melt_amount;
        logic [sfmb_pkg::DEPTH_W-1:0]       old_firn;
        logic [sfmb_pkg::DEPTH_W-1:0]       old_snow;
        logic [sfmb_pkg::DEPTH_W-1:0]       accumulation;
    } cell_t;

    typedef struct packed {
        logic signed [sfmb_pkg::CHG_W-1:0]  firn_change;
        logic signed [sfmb_pkg::CHG_W-1:0]  snow_change;
        logic signed [sfmb_pkg::MELT_W-1:0] melt_out;
        logic signed [sfmb_pkg::CHG_W-1:0]  runoff;
        logic signed [sfmb_pkg::CHG_W-1:0]  mass_balance;
    } balance_t;

    typedef struct packed {
        cell_t    stim;
        logic     typed;
        balance_t want;
    } dir_row_t;

    logic                            aclk = 1'b0;
    logic                            aresetn = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [sfmb_pkg::S_TDATA_W-1:0]  s_tdata = '0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [sfmb_pkg::M_TDATA_W-1:0]  m_tdata;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [sfmb_pkg::CFG_IDX_W-1:0]  cfg_index = sfmb_pkg::CFG_ALL_MELT;
    logic [sfmb_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    logic                        rfz_all_melt = sfmb_pkg::RST_ALL_MELT;
    logic [sfmb_pkg::TEMP_W-1:0] rfz_full_temp = sfmb_pkg::RST_T_FULL;
    logic [sfmb_pkg::TEMP_W-1:0] rfz_none_temp = sfmb_pkg::RST_T_NONE;

    balance_t pending_balances[$];
    dir_row_t dir_rows[DIR_ROWS];
    int       n_fail = 0;
    int       send_idle_pct = 0;
    int       recv_stall_pct = 0;

    snow_firn_mass_balance_step u_dut (.*);

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic balance_t balance_cell(input cell_t c);
        longint t, lo, hi, thick, melt, ofirn, osnow, acc;
        longint frac, snow, firn, snow_m, firn_m, base, frozen, runoff, smb;
        balance_t r;
        t = longint'(c.air_temp);
        thick = longint'(c.thickness);
        melt = longint'($signed(c.melt_amount));
        ofirn = longint'(c.old_firn);
        osnow = longint'(c.old_snow);
        acc = longint'(c.accumulation);
        lo = longint'(rfz_full_temp);
        hi = longint'(rfz_none_temp);
        if (t <= lo) frac = MT;
        else if (t <= hi) frac = ((hi - t) * MT) / (hi - lo);
        else frac = 0;

        snow = (osnow < thick) ? osnow : thick;
        firn = (ofirn < thick - snow) ? ofirn : thick - snow;
        snow = snow + acc;
        snow_m = 0;
        firn_m = 0;
        if (melt > 0) begin
            if (melt <= snow) begin
                snow_m = melt;
            end else if (melt <= firn + snow) begin
                snow_m = snow;
                firn_m = melt - snow;
            end else begin
                snow_m = snow;
                firn_m = firn;
            end
        end

        base = rfz_all_melt ? melt : snow_m + firn_m;
        if (base < 0) frozen = -((-base * frac) / MT);
        else frozen = (base * frac) / MT;
        snow = snow - snow_m;
        firn = firn - firn_m;
        runoff = melt - frozen;
        smb = acc - runoff;
        if (thick + smb < 0) smb = -thick;

        r.firn_change = sfmb_pkg::CHG_W'(firn - ofirn);
        r.snow_change = sfmb_pkg::CHG_W'(snow - osnow);
        r.melt_out = sfmb_pkg::MELT_W'(melt);
        r.runoff = sfmb_pkg::CHG_W'(runoff);
        r.mass_balance = sfmb_pkg::CHG_W'(smb);
        return r;
    endfunction

    function automatic logic [sfmb_pkg::DEPTH_W-1:0] rand_depth();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return DEPTH_MAX;
            2: return sfmb_pkg::DEPTH_W'($urandom_range(0, 16 * MT));
            3, 4: return sfmb_pkg::DEPTH_W'($urandom_range(0, 256 * MT));
            default: return sfmb_pkg::DEPTH_W'($urandom);
        endcase
    endfunction

    // Melt is mostly aimed at the snow and firn boundaries so that every melt path is taken.
    function automatic cell_t random_cell();
        cell_t c;
        longint th, s, f, avail, m;
        c.thickness = rand_depth();
        c.old_snow = rand_depth();
        c.old_firn = rand_depth();
        if ($urandom_range(0, 3) == 0) c.accumulation = rand_depth();
        else c.accumulation = sfmb_pkg::DEPTH_W'($urandom_range(0, 4 * MT));
        case ($urandom_range(0, 4))
            0: c.air_temp = sfmb_pkg::TEMP_W'($urandom);
            1: c.air_temp = rfz_full_temp + sfmb_pkg::TEMP_W'($urandom_range(0, 128))
                            - sfmb_pkg::TEMP_W'(64);
            2: c.air_temp = rfz_none_temp + sfmb_pkg::TEMP_W'($urandom_range(0, 128))
                            - sfmb_pkg::TEMP_W'(64);
            3: c.air_temp = sfmb_pkg::TEMP_W'($urandom_range(rfz_full_temp, rfz_none_temp));
            default: c.air_temp = $urandom_range(0, 1) ? TEMP_MAX : '0;
        endcase

        th = longint'(c.thickness);
        s = (longint'(c.old_snow) < th) ? longint'(c.old_snow) : th;
        f = (longint'(c.old_firn) < th - s) ? longint'(c.old_firn) : th - s;
        avail = s + longint'(c.accumulation);
        case ($urandom_range(0, 6))
            0: m = longint'($urandom_range(0, 32'h3FFF_FFFF)) - 64'sd536870912;
            1: m = 0;
            2: m = -longint'($urandom_range(1, 64 * MT));
            3: m = (avail * longint'($urandom_range(0, 1024))) / 1024;
            4: m = avail + (f * longint'($urandom_range(0, 1024))) / 1024;
            5: m = $urandom_range(0, 1) ? avail : avail + f;
            default: m = avail + f + longint'($urandom_range(1, 16 * MT));
        endcase
        if (m > 536870911) m = 536870911;
        c.melt_amount = sfmb_pkg::MELT_W'(m);
        return c;
    endfunction

    task automatic push_cell(input cell_t c, input logic typed, input balance_t want);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {5'b0, c.accumulation, c.old_snow, c.old_firn, c.melt_amount,
                    c.thickness, c.air_temp};
        do @(posedge aclk); while (!s_tready);
        pending_balances.push_back(typed ? want : balance_cell(c));
    endtask

    task automatic wait_drain();
        s_tvalid <= 1'b0;
        while (pending_balances.size() != 0) @(posedge aclk);
    endtask

    task automatic apply_settings(input logic all_melt, input int full_t, input int none_t,
                                  input logic poke_unused);
        logic [sfmb_pkg::CFG_IDX_W-1:0]  idx[4];
        logic [sfmb_pkg::CFG_DATA_W-1:0] val[4];
        int n;
        idx = '{sfmb_pkg::CFG_ALL_MELT, sfmb_pkg::CFG_T_FULL, sfmb_pkg::CFG_T_NONE,
                CFG_UNUSED};
        val = '{{16'($urandom), all_melt}, sfmb_pkg::CFG_DATA_W'(full_t),
                sfmb_pkg::CFG_DATA_W'(none_t), sfmb_pkg::CFG_DATA_W'($urandom)};
        n = poke_unused ? 4 : 3;
        wait_drain();
        for (int k = 0; k < n; k++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[k];
            cfg_data <= val[k];
            do @(posedge aclk); while (!cfg_ready);
            case (idx[k])
                sfmb_pkg::CFG_ALL_MELT: rfz_all_melt = val[k][0];
                sfmb_pkg::CFG_T_FULL: rfz_full_temp = val[k];
                sfmb_pkg::CFG_T_NONE: rfz_none_temp = val[k];
                default: ;
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic run_random(input int n_cells, input int pause_at);
        for (int k = 0; k < n_cells; k++) begin
            if (k == pause_at) wait_drain();
            push_cell(random_cell(), 1'b0, '0);
        end
    endtask

    always @(posedge aclk) begin : check_results
        balance_t got;
        balance_t want;
        logic [sfmb_pkg::M_TDATA_W-4*sfmb_pkg::CHG_W-sfmb_pkg::MELT_W-1:0] pad;
        if (m_tvalid && m_tready) begin
            {pad, got.mass_balance, got.runoff, got.melt_out, got.snow_change,
             got.firn_change} = m_tdata;
            if (pending_balances.size() == 0) begin
                $error("result with no request outstanding: %h", m_tdata);
                n_fail++;
            end else begin
                want = pending_balances.pop_front();
                if (got.firn_change !== want.firn_change) begin
                    $error("firn_change expected %0d got %0d",
                           $signed(want.firn_change), $signed(got.firn_change));
                    n_fail++;
                end
                if (got.snow_change !== want.snow_change) begin
                    $error("snow_change expected %0d got %0d",
                           $signed(want.snow_change), $signed(got.snow_change));
                    n_fail++;
                end
                if (got.melt_out !== want.melt_out) begin
                    $error("melt_out expected %0d got %0d",
                           $signed(want.melt_out), $signed(got.melt_out));
                    n_fail++;
                end
                if (got.runoff !== want.runoff) begin
                    $error("runoff expected %0d got %0d",
                           $signed(want.runoff), $signed(got.runoff));
                    n_fail++;
                end
                if (got.mass_balance !== want.mass_balance) begin
                    $error("mass_balance expected %0d got %0d",
                           $signed(want.mass_balance), $signed(got.mass_balance));
                    n_fail++;
                end
            end
        end
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    initial begin : stimulus
        // Fields: air_temp, thickness, melt_amount, old_firn, old_snow, accumulation.
        // Typed results: firn_change, snow_change, melt_out, runoff, mass_balance.
        dir_rows = '{
            '{'{0, 0, 0, 0, 0, 0}, 1'b1, '{0, 0, 0, 0, 0}},
            '{'{TEMP_MAX, 0, -1, 0, 0, 0}, 1'b1, '{0, 0, -1, -1, 1}},
            '{'{0, 0, MT, 0, 0, 0}, 1'b1, '{0, 0, MT, 0, 0}},
            '{'{0, 0, 0, 0, DEPTH_MAX, 0}, 1'b1, '{0, -536870911, 0, 0, 0}},
            '{'{TEMP_MAX, 0, 536870911, 0, 0, 0}, 1'b1, '{0, 0, 536870911, 536870911, 0}},
            '{'{0, DEPTH_MAX, -536870912, 0, 0, 0}, 1'b1, '{0, 0, -536870912, 0, 0}},
            '{'{TEMP_MAX, DEPTH_MAX, 536870911, DEPTH_MAX, DEPTH_MAX, DEPTH_MAX}, 1'b0, '0},
            '{'{68608, 10 * MT, 2 * MT, 3 * MT, 2 * MT, MT}, 1'b0, '0},
            '{'{68609, 10 * MT, 5 * MT, 3 * MT, 2 * MT, MT}, 1'b0, '0},
            '{'{69248, 10 * MT, 10 * MT, 3 * MT, 2 * MT, MT}, 1'b0, '0},
            '{'{69888, 10 * MT, MT, 3 * MT, 2 * MT, 0}, 1'b0, '0},
            '{'{69889, 5 * MT, 20 * MT, 0, 0, 0}, 1'b0, '0},
            '{'{69000, 4 * MT, 0, 3 * MT, 3 * MT, 0}, 1'b0, '0},
            '{'{69000, 10 * MT, -3 * MT, 3 * MT, 2 * MT, MT}, 1'b0, '0},
            '{'{68000, 0, 1, 0, 0, DEPTH_MAX}, 1'b0, '0},
            '{'{69500, 10 * MT, 5 * MT, 3 * MT, 2 * MT, 0}, 1'b0, '0},
            '{'{69500, 10 * MT, 2 * MT, 3 * MT, 2 * MT, 0}, 1'b0, '0},
            '{'{69887, DEPTH_MAX, 536870911, DEPTH_MAX, DEPTH_MAX, 0}, 1'b0, '0},
            '{'{'h15555, 'h0AAAAAAA, 'h15555555, 'h15555555, 'h0AAAAAAA, 'h15555555},
              1'b0, '0},
            '{'{'h0AAAA, 'h15555555, 'h2AAAAAAA, 'h0AAAAAAA, 'h15555555, 'h0AAAAAAA},
              1'b0, '0}
        };
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[r]) push_cell(dir_rows[r].stim, dir_rows[r].typed, dir_rows[r].want);
        run_random(125, -1);

        apply_settings(1'b0, 0, 131071, 1'b0);
        send_idle_pct = 69;
        run_random(125, -1);

        // Thresholds in the wrong order; the sender also stops once until the pipe is empty.
        apply_settings(1'b1, 131071, 0, 1'b0);
        send_idle_pct = 0;
        recv_stall_pct = 69;
        run_random(125, 60);

        apply_settings(1'b0, 70000, 70000, 1'b1);
        send_idle_pct = 38;
        recv_stall_pct = 38;
        run_random(125, -1);

        apply_settings(1'b1, 1000, 1001, 1'b0);
        run_random(125, -1);

        apply_settings(1'b0, 68000, 72000, 1'b0);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        run_random(125, -1);

        wait_drain();
        repeat (16) @(posedge aclk);
        if (n_fail == 0) begin
            $display("[snow_firn_mass_balance_step] OK");
        end else begin
            $display("[snow_firn_mass_balance_step] ERROR");
        end
        $finish;
    end

    initial begin : watchdog
        #400000;
        $display("[snow_firn_mass_balance_step] ERROR");
        $finish;
    end

endmodule
